/* hdl/prf_pkg.sv */
// ----------------------------------------------------------------------------
// prf_pkg
// Shared types and codes for the packet ring queue with resumable reads.
// ----------------------------------------------------------------------------
package prf_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_TOO_LONG = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_BYTE     = 3'd4
  } status_e;

  // Request codes on the input channel
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Width of the count field of a result
  localparam int unsigned CountWidth = 10;

  // End-of-message report from the ingress side
  typedef struct packed {
    logic    commit;   // message stored in its slot
    status_e status;   // accepted, too long or full
  } wr_evt_t;

endpackage

/* hdl/prf_if.sv */
// ----------------------------------------------------------------------------
// prf_in_if / prf_out_if
// Valid/ready channels carrying request words and result words.
// ----------------------------------------------------------------------------
interface prf_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  logic       last_byte;
  logic [6:0] read_max;

  modport source(output valid, mode, data_byte, last_byte, read_max, input ready);
  modport sink(input valid, mode, data_byte, last_byte, read_max, output ready);
endinterface

interface prf_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] out_byte;
  logic       message_done;
  logic       run_last;
  logic [9:0] byte_count;

  modport source(output valid, status, out_byte, message_done, run_last, byte_count,
                 input ready);
  modport sink(input valid, status, out_byte, message_done, run_last, byte_count,
               output ready);
endinterface

/* hdl/prf_ingress.sv */
// ----------------------------------------------------------------------------
// prf_ingress
// Write side of the ring: tracks slot, position and drop reason of the
// message being received and reports its end.
// ----------------------------------------------------------------------------
module prf_ingress #(
  parameter int unsigned QUEUE_DEPTH  = 8,
  parameter int unsigned PACKET_BYTES = 512,
  localparam int unsigned SW = $clog2(QUEUE_DEPTH),
  localparam int unsigned PW = $clog2(PACKET_BYTES + 2),
  localparam int unsigned LW = $clog2(PACKET_BYTES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic             last_i,
  input  logic [SW-1:0]    rd_slot_i,
  output logic             wr_en_o,
  output logic [SW-1:0]    wr_slot_o,
  output logic [PW-1:0]    wr_pos_o,
  output logic [LW-1:0]    len_o,
  output prf_pkg::wr_evt_t evt_o
);

  logic [SW-1:0]    slot_q, slot_d, slot_nxt;
  logic [PW-1:0]    pos_q, pos_d, pos_inc;
  prf_pkg::status_e drop_q, drop_d, drop_a, drop_b;
  logic             full;

  assign slot_nxt = (slot_q == SW'(QUEUE_DEPTH - 1)) ? '0 : slot_q + SW'(1);

  // Check the ring for room on the first word of a message
  assign full = (pos_q == '0) && (drop_q == prf_pkg::ST_ACCEPTED) &&
                (slot_nxt == rd_slot_i);

  always_comb begin
    drop_a = full ? prf_pkg::ST_FULL : drop_q;
    drop_b = drop_a;
    wr_en_o = 1'b0;
    if (drop_a == prf_pkg::ST_ACCEPTED) begin
      if (32'(pos_q) >= PACKET_BYTES) begin
        drop_b = prf_pkg::ST_TOO_LONG;
      end else begin
        wr_en_o = take_i;
      end
    end
    // Saturate one past the slot size
    pos_inc = (32'(pos_q) < PACKET_BYTES + 1) ? pos_q + PW'(1) : pos_q;
  end

  // Advance position; close the message on its last word
  always_comb begin
    slot_d = slot_q;
    pos_d  = pos_q;
    drop_d = drop_q;
    if (take_i) begin
      if (last_i) begin
        pos_d  = '0;
        drop_d = prf_pkg::ST_ACCEPTED;
        if (drop_b == prf_pkg::ST_ACCEPTED) begin
          slot_d = slot_nxt;
        end
      end else begin
        pos_d  = pos_inc;
        drop_d = drop_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      pos_q  <= '0;
      drop_q <= prf_pkg::ST_ACCEPTED;
    end else begin
      slot_q <= slot_d;
      pos_q  <= pos_d;
      drop_q <= drop_d;
    end
  end

  assign wr_slot_o    = slot_q;
  assign wr_pos_o     = pos_q;
  assign len_o        = LW'(pos_inc);
  assign evt_o.commit = take_i && last_i && (drop_b == prf_pkg::ST_ACCEPTED);
  assign evt_o.status = drop_b;

endmodule

/* hdl/packet_ring_fifo_partial_read.sv */
// ----------------------------------------------------------------------------
// packet_ring_fifo_partial_read
// Receive queue of whole messages in a ring of slots with resumable reads.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries request words. mode 0 is one message byte (last_byte marks
//   the end); mode 1 is a read of up to read_max bytes of the oldest message.
//   out_o carries result words, each registered.
//   Only the last byte of a message gives a result: accepted with its
//   length, too long, or queue full. A read first fetches the stored
//   length and sets up the run, then streams the bytes through the
//   single read port of the byte memory, fetching each next byte while
//   the previous one goes out. run_last marks the final word of a run and
//   message_done the word that freed the slot. A read of an empty queue
//   gives one nothing-to-read word; a read of zero bytes gives none.
//   in_i.ready is low while a read run is in progress or the output word
//   is held. When out_o.ready is low the current word holds and the run
//   pauses; nothing is lost.
//   Reset empties the ring at once; stored bytes and lengths are not
//   cleared and are only read after they were written.
// ----------------------------------------------------------------------------
module packet_ring_fifo_partial_read #(
  parameter int unsigned QUEUE_DEPTH  = 8,
  parameter int unsigned PACKET_BYTES = 512,
  parameter int unsigned MAX_READ     = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  prf_in_if.sink    in_i,
  prf_out_if.source out_o
);

  localparam int unsigned SW = $clog2(QUEUE_DEPTH);
  localparam int unsigned PW = $clog2(PACKET_BYTES + 2);
  localparam int unsigned LW = $clog2(PACKET_BYTES + 1);
  localparam int unsigned AW = $clog2(QUEUE_DEPTH * PACKET_BYTES);
  localparam int unsigned CW = $clog2(MAX_READ + 1);
  localparam int unsigned MW = prf_pkg::CountWidth;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LEN  = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e        state_q, state_d;
  logic [SW-1:0] rd_slot_q, rd_slot_d, rd_slot_nxt;
  logic [LW-1:0] rd_pos_q, rd_pos_d, rd_pos_sel;
  logic [CW-1:0] want_q, want_d, want_sat;
  logic [CW-1:0] n_q, n_d, n_calc;
  logic [CW-1:0] k_q, k_d;
  logic          freed_q, freed_d, freed_calc;
  logic [LW-1:0] len_rd_q, len_eff, rem;
  logic [7:0]    rd_data_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          run_end;

  logic             out_valid_q, out_valid_d, out_load, out_free;
  prf_pkg::status_e out_status_q, out_status_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_done_q, out_done_d;
  logic             out_last_q, out_last_d;
  logic [MW-1:0]    out_count_q, out_count_d;

  logic             accept, take_byte, empty;
  logic             wr_en;
  logic [SW-1:0]    wr_slot;
  logic [PW-1:0]    wr_pos;
  logic [LW-1:0]    wr_len;
  prf_pkg::wr_evt_t wr_evt;

  logic [7:0]    pkt_mem [QUEUE_DEPTH * PACKET_BYTES];
  logic [LW-1:0] len_mem [QUEUE_DEPTH];

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign accept    = in_i.valid && in_i.ready;
  assign take_byte = accept && (in_i.mode == prf_pkg::MODE_BYTE);

  prf_ingress #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PACKET_BYTES(PACKET_BYTES)
  ) u_ingress (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take_byte),
    .last_i   (in_i.last_byte),
    .rd_slot_i(rd_slot_q),
    .wr_en_o  (wr_en),
    .wr_slot_o(wr_slot),
    .wr_pos_o (wr_pos),
    .len_o    (wr_len),
    .evt_o    (wr_evt)
  );

  assign empty       = (rd_slot_q == wr_slot);
  assign rd_slot_nxt = (rd_slot_q == SW'(QUEUE_DEPTH - 1)) ? '0 : rd_slot_q + SW'(1);
  assign want_sat    = (32'(in_i.read_max) > MAX_READ) ? CW'(MAX_READ)
                                                       : CW'(in_i.read_max);

  // Size the run from the stored length and the resume point
  always_comb begin
    len_eff = (32'(len_rd_q) > PACKET_BYTES) ? LW'(PACKET_BYTES) : len_rd_q;
    rem     = (rd_pos_q < len_eff) ? len_eff - rd_pos_q : '0;
    n_calc  = (32'(rem) > 32'(want_q)) ? want_q : CW'(rem);
    freed_calc = (32'(rd_pos_q) + 32'(n_calc)) >= 32'(len_eff);
  end

  // Memory addresses: slot base plus position
  assign rd_pos_sel = (state_q == S_EMIT) ? rd_pos_q + LW'(1) : rd_pos_q;
  assign rd_addr    = AW'(32'(rd_slot_q) * PACKET_BYTES + 32'(rd_pos_sel));
  assign wr_addr    = AW'(32'(wr_slot) * PACKET_BYTES + 32'(wr_pos));
  assign run_end    = (32'(k_q) + 32'd1 == 32'(n_q));

  // Sequencer
  always_comb begin
    state_d   = state_q;
    rd_slot_d = rd_slot_q;
    rd_pos_d  = rd_pos_q;
    want_d    = want_q;
    n_d       = n_q;
    k_d       = k_q;
    freed_d   = freed_q;
    rd_en     = 1'b0;

    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_byte_d   = out_byte_q;
    out_done_d   = out_done_q;
    out_last_d   = out_last_q;
    out_count_d  = out_count_q;

    case (state_q)
      S_IDLE: begin
        if (take_byte && in_i.last_byte) begin
          out_load     = 1'b1;
          out_status_d = wr_evt.status;
          out_byte_d   = '0;
          out_done_d   = 1'b0;
          out_last_d   = 1'b1;
          out_count_d  = wr_evt.commit ? MW'(wr_len) : '0;
        end else if (accept && (in_i.mode == prf_pkg::MODE_READ) &&
                     (in_i.read_max != '0)) begin
          if (empty) begin
            out_load     = 1'b1;
            out_status_d = prf_pkg::ST_EMPTY;
            out_byte_d   = '0;
            out_done_d   = 1'b0;
            out_last_d   = 1'b1;
            out_count_d  = '0;
          end else begin
            want_d  = want_sat;
            state_d = S_LEN;
          end
        end
      end
      S_LEN: begin
        n_d     = n_calc;
        freed_d = freed_calc;
        k_d     = '0;
        if (n_calc == '0) begin
          // Nothing left in the slot: free it silently
          if (freed_calc) begin
            rd_slot_d = rd_slot_nxt;
            rd_pos_d  = '0;
          end
          state_d = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = prf_pkg::ST_BYTE;
          out_byte_d   = rd_data_q;
          out_done_d   = freed_q && run_end;
          out_last_d   = run_end;
          out_count_d  = MW'(k_q) + MW'(1);
          if (run_end) begin
            if (freed_q) begin
              rd_slot_d = rd_slot_nxt;
              rd_pos_d  = '0;
            end else begin
              rd_pos_d = rd_pos_q + LW'(1);
            end
            state_d = S_IDLE;
          end else begin
            // Fetch the next byte while this one goes out
            rd_en    = 1'b1;
            rd_pos_d = rd_pos_q + LW'(1);
            k_d      = k_q + CW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_slot_q   <= '0;
      rd_pos_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_slot_q   <= rd_slot_d;
      rd_pos_q    <= rd_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Run bookkeeping and output word
  always_ff @(posedge clk_i) begin
    want_q       <= want_d;
    n_q          <= n_d;
    k_q          <= k_d;
    freed_q      <= freed_d;
    out_status_q <= out_status_d;
    out_byte_q   <= out_byte_d;
    out_done_q   <= out_done_d;
    out_last_q   <= out_last_d;
    out_count_q  <= out_count_d;
  end

  // Message byte memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pkt_mem[wr_addr] <= in_i.data_byte;
    end
    if (rd_en) begin
      rd_data_q <= pkt_mem[rd_addr];
    end
  end

  // Slot length memory
  always_ff @(posedge clk_i) begin
    if (wr_evt.commit) begin
      len_mem[wr_slot] <= wr_len;
    end
    len_rd_q <= len_mem[rd_slot_q];
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.out_byte     = out_byte_q;
  assign out_o.message_done = out_done_q;
  assign out_o.run_last     = out_last_q;
  assign out_o.byte_count   = out_count_q;

  // A read run never works on an empty ring
  a_run_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (rd_slot_q != wr_slot))
    else $error("read run on empty ring");

  // Every word that is not a byte of a run ends its request
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != prf_pkg::ST_BYTE)) |-> out_last_q)
    else $error("status word without run_last");

  // A delivered byte count stays within the read limit
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == prf_pkg::ST_BYTE)) |->
      ((out_count_q != '0) && (32'(out_count_q) <= MAX_READ)))
    else $error("byte count out of range");

  // A run only starts after a length lookup
  a_emit_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_EMIT) |-> $past(state_q == S_LEN))
    else $error("run started without length lookup");

endmodule
